// ----- src/upd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared types and constants for the front, queue and back of the decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LC_A    = 8'h61;
  localparam logic [7:0] CHAR_LC_F    = 8'h66;
  localparam logic [7:0] CHAR_UC_A    = 8'h41;
  localparam logic [7:0] CHAR_UC_F    = 8'h46;
  localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HEX1 = 2'd2,
    PH_DROP = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       is_pct;
    logic       is_plus;
    logic       is_hex;
    logic [3:0] hex_val;
  } item_t;

endpackage
`default_nettype wire

// ----- src/url_percent_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder
// Decodes percent escapes and optional plus signs in a character stream.
// ----------------------------------------------------------------------------
// A character accepted into the queue is written to a queue entry; the back
// takes the queue head directly and registers the result beat from it.
// Throughput: one character per cycle while the queue is not full and the
// consumer does not stall the result beat. Synchronous reset empties the
// queue, returns the escape state to idle and clears the plus-to-space mode.
module url_percent_decoder_top
  import upd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       end_of_string,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            string_done,
  output logic            status,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data
);

  logic  plus_to_space;
  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  q_valid;
  item_t q_item;
  logic  pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_to_space <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      plus_to_space <= cfg_data;
    end
  end

  upd_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char       (in_char),
    .end_of_string (end_of_string),
    .push          (push),
    .push_item     (push_item),
    .queue_full    (queue_full)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop_valid (q_valid),
    .pop_item  (q_item),
    .pop       (pop)
  );

  upd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .plus_to_space (plus_to_space),
    .item_valid    (q_valid),
    .item          (q_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .string_done   (string_done),
    .status        (status)
  );

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> string_done && !byte_valid)
    else $error("error beat must close the string without a byte");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> status)
    else $error("beat without a byte must carry an error status");

  assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

endmodule
`default_nettype wire

// ----- src/upd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder front
// Accepts input beats and classifies each character for the back.
// ----------------------------------------------------------------------------
module upd_front
  import upd_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       end_of_string,
  output logic            push,
  output item_t           push_item,
  input  wire logic       queue_full
);

  logic       is_digit;
  logic       is_lower;
  logic       is_upper;
  logic [7:0] offset;

  always_comb begin
    is_digit = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
    is_lower = (in_char >= CHAR_LC_A) && (in_char <= CHAR_LC_F);
    is_upper = (in_char >= CHAR_UC_A) && (in_char <= CHAR_UC_F);
    if (is_digit) begin
      offset = in_char - CHAR_ZERO;
    end else if (is_lower) begin
      offset = in_char - CHAR_LC_A + {4'd0, HEX_ALPHA_BASE};
    end else if (is_upper) begin
      offset = in_char - CHAR_UC_A + {4'd0, HEX_ALPHA_BASE};
    end else begin
      offset = 8'd0;
    end
    push_item.ch      = in_char;
    push_item.eos     = end_of_string;
    push_item.is_pct  = (in_char == CHAR_PERCENT);
    push_item.is_plus = (in_char == CHAR_PLUS);
    push_item.is_hex  = is_digit || is_lower || is_upper;
    push_item.hex_val = offset[3:0];
  end

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

endmodule
`default_nettype wire

// ----- src/upd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder queue
// Short first-in first-out queue of classified characters.
// ----------------------------------------------------------------------------
module upd_queue
  import upd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  output logic       pop_valid,
  output item_t      pop_item,
  input  wire logic  pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  item_t         entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == FULL_COUNT);
  assign pop_valid = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/upd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder back
// Runs the escape state machine and holds the result beat for the consumer.
// ----------------------------------------------------------------------------
module upd_back
  import upd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       plus_to_space,
  input  wire logic       item_valid,
  input  wire item_t      item,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            string_done,
  output logic            status
);

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;
  logic       emit;
  logic [7:0] r_byte;
  logic       r_valid;
  logic       r_done;
  logic       r_status;

  assign pop = item_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      high_nibble <= '0;
    end else if (pop) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    emit             = 1'b0;
    r_byte           = 8'd0;
    r_valid          = 1'b0;
    r_done           = item.eos;
    r_status         = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (item.is_pct) begin
          if (item.eos) begin
            emit     = 1'b1;
            r_status = 1'b1;
          end else begin
            phase_next = PH_PCT;
          end
        end else begin
          emit    = 1'b1;
          r_valid = 1'b1;
          r_byte  = (plus_to_space && item.is_plus) ? CHAR_SPACE : item.ch;
        end
      end
      PH_PCT: begin
        if (!item.is_hex || item.eos) begin
          emit       = item.eos;
          r_status   = 1'b1;
          phase_next = item.eos ? PH_IDLE : PH_DROP;
        end else begin
          high_nibble_next = item.hex_val;
          phase_next       = PH_HEX1;
        end
      end
      PH_HEX1: begin
        if (!item.is_hex) begin
          emit       = item.eos;
          r_status   = 1'b1;
          phase_next = item.eos ? PH_IDLE : PH_DROP;
        end else begin
          emit       = 1'b1;
          r_valid    = 1'b1;
          r_byte     = {high_nibble, item.hex_val};
          phase_next = PH_IDLE;
        end
      end
      PH_DROP: begin
        if (item.eos) begin
          emit       = 1'b1;
          r_status   = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_byte    <= r_byte;
      byte_valid  <= r_valid;
      string_done <= r_done;
      status      <= r_status;
    end
  end

endmodule
`default_nettype wire

// ----- test/url_percent_decoder_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder testbench
// Feeds encoded strings through the decoder under random source gaps and sink
// stalls, computes the decoded bytes and string status alongside it, and checks
// every result beat in order. Runs directed corner strings, then random
// strings, with the plus-to-space mode switched between phases while idle.
// ----------------------------------------------------------------------------
module url_percent_decoder_top_tb;
  import upd_pkg::*;

  localparam int unsigned N_RANDOM     = 1850;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam logic [7:0] HEX_EDGES [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

  typedef struct {
    logic [7:0] ch;
    logic       eos;
  } enc_char_t;

  typedef struct packed {
    logic [7:0] data;
    logic       bv;
    logic       done;
    logic       status;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic       status;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  enc_char_t   char_q[$];
  decoded_t    decoded_q[$];
  phase_t      esc_phase = PH_IDLE;
  logic [3:0]  esc_high = 4'd0;
  logic        mode_plus = 1'b0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  int unsigned quiet = 0;
  int unsigned n_queued = 0;
  int unsigned n_chars = 0;
  int unsigned n_results = 0;
  int unsigned n_strings = 0;
  int unsigned n_errors = 0;
  int unsigned mode_writes = 0;
  int unsigned fails = 0;

  url_percent_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char       (in_char),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .string_done   (string_done),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial forever #1 clk = ~clk;

  function automatic logic hex_nibble(input logic [7:0] ch, output logic [3:0] v);
    v = 4'd0;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      v = 4'(ch - CHAR_ZERO);
      return 1'b1;
    end
    if (ch >= CHAR_LC_A && ch <= CHAR_LC_F) begin
      v = HEX_ALPHA_BASE + 4'(ch - CHAR_LC_A);
      return 1'b1;
    end
    if (ch >= CHAR_UC_A && ch <= CHAR_UC_F) begin
      v = HEX_ALPHA_BASE + 4'(ch - CHAR_UC_A);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < HEX_ALPHA_BASE) return 8'(CHAR_ZERO + v);
    return 8'((upper ? CHAR_UC_A : CHAR_LC_A) + (v - HEX_ALPHA_BASE));
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [3:0] v;
    c = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: c = CHAR_PLUS;
      1: c = HEX_EDGES[$urandom_range(0, 5)];
      default: while (hex_nibble(c, v)) c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CHAR_PERCENT) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Advances the escape state by one character and queues any resulting beat.
  task automatic decode_char(input logic [7:0] ch, input logic eos);
    decoded_t   r;
    logic [3:0] hv;
    logic       is_hex;
    logic       bad;
    logic       emit;
    r = '0;
    bad = 1'b0;
    emit = 1'b0;
    is_hex = hex_nibble(ch, hv);
    case (esc_phase)
      PH_IDLE: begin
        if (ch == CHAR_PERCENT) begin
          if (eos) bad = 1'b1;
          else esc_phase = PH_PCT;
        end else begin
          r.data = (mode_plus && ch == CHAR_PLUS) ? CHAR_SPACE : ch;
          r.bv = 1'b1;
          r.done = eos;
          emit = 1'b1;
        end
      end
      PH_PCT: begin
        if (!is_hex || eos) bad = 1'b1;
        else begin
          esc_high = hv;
          esc_phase = PH_HEX1;
        end
      end
      PH_HEX1: begin
        if (!is_hex) bad = 1'b1;
        else begin
          esc_phase = PH_IDLE;
          r.data = {esc_high, hv};
          r.bv = 1'b1;
          r.done = eos;
          emit = 1'b1;
        end
      end
      default: begin
        if (eos) begin
          esc_phase = PH_IDLE;
          r.done = 1'b1;
          r.status = 1'b1;
          emit = 1'b1;
        end
      end
    endcase
    if (bad) begin
      esc_phase = eos ? PH_IDLE : PH_DROP;
      r.done = eos;
      r.status = eos;
      emit = eos;
    end
    if (emit) decoded_q.insert(decoded_q.size(), r);
  endtask

  task automatic push_char(input logic [7:0] ch, input logic eos);
    enc_char_t e;
    e.ch = ch;
    e.eos = eos;
    char_q.insert(char_q.size(), e);
    n_queued++;
  endtask

  task automatic push_escape(input logic eos);
    push_char(CHAR_PERCENT, 1'b0);
    push_char(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
    push_char(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), eos);
  endtask

  // Mostly well-formed strings; about one in six carries a bad or cut-off escape.
  task automatic push_string();
    int unsigned toks;
    int unsigned k;
    int unsigned brk;
    logic        last;
    logic        broken;
    toks = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                        : $urandom_range(1, 8);
    broken = ($urandom_range(0, 5) == 0);
    brk = $urandom_range(0, toks - 1);
    for (k = 0; k < toks; k++) begin
      last = (k == toks - 1);
      if (broken && k == brk) begin
        case ($urandom_range(0, 3))
          0: begin
            push_char(CHAR_PERCENT, 1'b0);
            push_char(non_hex_char(), last);
          end
          1: begin
            push_char(CHAR_PERCENT, 1'b0);
            push_char(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))),
                      1'b0);
            push_char(non_hex_char(), last);
          end
          2: begin
            push_char(CHAR_PERCENT, 1'b1);
            return;
          end
          default: begin
            push_char(CHAR_PERCENT, 1'b0);
            push_char(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))),
                      1'b1);
            return;
          end
        endcase
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: push_escape(last);
          4, 5: push_char(CHAR_PLUS, last);
          6: push_char(8'($urandom_range(0, 255)), last);
          default: push_char(plain_char(), last);
        endcase
      end
    end
  endtask

  task automatic push_noise_string();
    int unsigned len;
    int unsigned k;
    logic [7:0]  c;
    len = $urandom_range(1, 6);
    for (k = 0; k < len; k++) begin
      case ($urandom_range(0, 3))
        0: c = CHAR_PERCENT;
        1: c = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        2: c = CHAR_PLUS;
        default: c = 8'($urandom_range(0, 255));
      endcase
      push_char(c, k == len - 1);
    end
  endtask

  // Called just after a rising edge with the block idle.
  task automatic set_mode(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    mode_plus = v;
    mode_writes++;
  endtask

  task automatic settle();
    do @(negedge clk); while (char_q.size() != 0 || in_valid || decoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_in
    int unsigned w;
    enc_char_t   c;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        decode_char(in_char, end_of_string);
        n_chars++;
        if ($urandom_range(0, 47) == 0) in_calm = !in_calm;
        w = draw_wait(in_calm);
      end else begin
        w = in_gap;
      end
      if (w == 0 && char_q.size() != 0) begin
        c = char_q.pop_front();
        in_valid <= 1'b1;
        in_char <= c.ch;
        end_of_string <= c.eos;
      end else begin
        in_valid <= 1'b0;
        in_gap <= (w != 0) ? w - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin : watch_out
    int unsigned w;
    decoded_t    want;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else if (out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        fails++;
        $display("%0t: result beat with none expected: out_byte %h byte_valid %b",
                 $time, out_byte, byte_valid);
        $display("%0t:   string_done %b status %b", $time, string_done, status);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data) begin
          fails++;
          $display("%0t: out_byte expected %h, actual %h", $time, want.data, out_byte);
        end
        if (byte_valid !== want.bv) begin
          fails++;
          $display("%0t: byte_valid expected %b, actual %b", $time, want.bv, byte_valid);
        end
        if (string_done !== want.done) begin
          fails++;
          $display("%0t: string_done expected %b, actual %b", $time, want.done, string_done);
        end
        if (status !== want.status) begin
          fails++;
          $display("%0t: status expected %b, actual %b", $time, want.status, status);
        end
      end
      n_results++;
      if (string_done === 1'b1) n_strings++;
      if (status === 1'b1) n_errors++;
      if ($urandom_range(0, 47) == 0) out_calm = !out_calm;
      w = draw_wait(out_calm);
      out_hold <= w;
      out_stall <= (w != 0);
    end else if (out_hold != 0) begin
      out_hold <= out_hold - 1;
      out_stall <= (out_hold > 1);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned goal;
    int unsigned random_start;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Plus signs pass through unchanged here.
    set_mode(1'b0);
    @(negedge clk);
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b1);
    push_char(CHAR_PERCENT, 1'b0);
    push_char(8'h66, 1'b0);
    push_char(8'h46, 1'b1);
    push_char(CHAR_PERCENT, 1'b0);
    push_char(8'h30, 1'b0);
    push_char(8'h39, 1'b0);
    push_char(CHAR_PLUS, 1'b1);
    push_char(CHAR_PERCENT, 1'b1);
    push_char(CHAR_PERCENT, 1'b0);
    push_char(8'h34, 1'b1);
    push_char(CHAR_PERCENT, 1'b0);
    push_char(8'h47, 1'b0);
    push_char(8'h41, 1'b0);
    push_char(8'h7A, 1'b1);
    push_char(CHAR_PERCENT, 1'b0);
    push_char(CHAR_PLUS, 1'b1);
    push_char(CHAR_PERCENT, 1'b0);
    push_char(8'h61, 1'b0);
    push_char(8'h2F, 1'b1);
    settle();

    // Plus signs become spaces, but still break an escape.
    set_mode(1'b1);
    @(negedge clk);
    push_char(CHAR_PLUS, 1'b0);
    push_char(CHAR_PLUS, 1'b1);
    push_char(CHAR_PERCENT, 1'b0);
    push_char(CHAR_PLUS, 1'b0);
    push_char(CHAR_PLUS, 1'b1);
    settle();

    ph = 0;
    random_start = n_queued;
    while (n_queued - random_start < N_RANDOM) begin
      set_mode(ph[0]);
      @(negedge clk);
      goal = n_queued + $urandom_range(150, 300);
      if (goal > random_start + N_RANDOM) goal = random_start + N_RANDOM;
      while (n_queued < goal) begin
        if ($urandom_range(0, 7) == 0) push_noise_string();
        else push_string();
      end
      settle();
      ph++;
    end

    $display("Run covered %0d characters and %0d result beats over %0d closed strings,",
             n_chars, n_results, n_strings);
    $display("%0d of them bad; the plus mode was written %0d times across %0d random phases.",
             n_errors, mode_writes, ph);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
